>>> rtl/core/mqm_pkg.sv
// Shared types and codes for the multi-queue manager.
// Used by the controller, the datapath and the top level.
package mqm_pkg;

  localparam logic [2:0] CMD_NEW   = 3'd0;
  localparam logic [2:0] CMD_MOVE  = 3'd1;
  localparam logic [2:0] CMD_QUERY = 3'd2;
  localparam logic [2:0] CMD_COUNT = 3'd3;
  localparam logic [2:0] CMD_LIST  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_QUEUE = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;
  localparam logic [1:0] ST_UNKNOWN   = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_UNLINK, S_APPEND, S_LINK, S_RESP, S_LIST_RD, S_LIST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    VS_ZERO, VS_QUEUE, VS_COUNT, VS_CUR
  } vsel_t;

  typedef struct packed {
    logic       in_load;
    logic       list_init;
    logic       list_step;
    logic       rd_cur;
    logic       do_unlink;
    logic       do_append;
    logic       do_link;
    logic       res_load;
    logic [1:0] res_status;
    logic       res_hv;
    logic       res_last;
    vsel_t      res_vsel;
  } ctl_cmd_t;

  typedef struct packed {
    logic q_ok;
    logic cid_ok;
    logic known;
    logic same_q;
    logic cur_nil;
    logic prev_nil;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/core/mqm_ctrl.sv
// Command sequencer of the multi-queue manager.
// Depends on mqm_pkg; drives the datapath through ctl_cmd_t.
module mqm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [2:0]        in_cmd,
  output logic              in_ready,
  input  mqm_pkg::dp_stat_t stat,
  output mqm_pkg::ctl_cmd_t ctl
);
  import mqm_pkg::*;

  state_t     state, state_next;
  logic [2:0] cmd_r, cmd_r_next;
  logic [1:0] st_r, st_r_next;
  logic       hv_r, hv_r_next;
  vsel_t      vsel_r, vsel_r_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    cmd_r  <= cmd_r_next;
    st_r   <= st_r_next;
    hv_r   <= hv_r_next;
    vsel_r <= vsel_r_next;
  end

  always_comb begin
    state_next  = state;
    cmd_r_next  = cmd_r;
    st_r_next   = st_r;
    hv_r_next   = hv_r;
    vsel_r_next = vsel_r;
    in_ready    = 1'b0;
    ctl         = '0;
    ctl.res_vsel = VS_ZERO;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.in_load = 1'b1;
          cmd_r_next  = in_cmd;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        st_r_next   = ST_OK;
        hv_r_next   = 1'b0;
        vsel_r_next = VS_ZERO;
        state_next  = S_RESP;
        priority case (cmd_r)
          CMD_NEW: begin
            if (!stat.q_ok) st_r_next = ST_BAD_QUEUE;
            else if (!stat.cid_ok) st_r_next = ST_UNKNOWN;
            else if (stat.known) st_r_next = ST_DUPLICATE;
            else state_next = S_APPEND;
          end
          CMD_MOVE: begin
            if (!stat.q_ok) st_r_next = ST_BAD_QUEUE;
            else if (!stat.known) st_r_next = ST_UNKNOWN;
            else if (!stat.same_q) state_next = S_UNLINK;
          end
          CMD_QUERY: begin
            if (!stat.known) begin
              st_r_next = ST_UNKNOWN;
            end else begin
              hv_r_next   = 1'b1;
              vsel_r_next = VS_QUEUE;
            end
          end
          CMD_COUNT: begin
            if (!stat.q_ok) begin
              st_r_next = ST_BAD_QUEUE;
            end else begin
              hv_r_next   = 1'b1;
              vsel_r_next = VS_COUNT;
            end
          end
          CMD_LIST: begin
            if (!stat.q_ok) begin
              st_r_next = ST_BAD_QUEUE;
            end else begin
              ctl.list_init = 1'b1;
              state_next    = S_LIST_RD;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_UNLINK: begin
        ctl.do_unlink = 1'b1;
        state_next    = S_APPEND;
      end
      S_APPEND: begin
        ctl.do_append = 1'b1;
        state_next    = S_LINK;
      end
      S_LINK: begin
        ctl.do_link = 1'b1;
        state_next  = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          ctl.res_load   = 1'b1;
          ctl.res_status = st_r;
          ctl.res_hv     = hv_r;
          ctl.res_last   = 1'b1;
          ctl.res_vsel   = vsel_r;
          state_next     = S_IDLE;
        end
      end
      S_LIST_RD: begin
        // The prev link of the current entry is read during this cycle.
        ctl.rd_cur = 1'b1;
        if (stat.cur_nil) begin
          st_r_next   = ST_OK;
          hv_r_next   = 1'b0;
          vsel_r_next = VS_ZERO;
          state_next  = S_RESP;
        end else begin
          state_next = S_LIST_EMIT;
        end
      end
      S_LIST_EMIT: begin
        ctl.rd_cur = 1'b1;
        if (stat.out_free) begin
          ctl.res_load   = 1'b1;
          ctl.res_status = ST_OK;
          ctl.res_hv     = 1'b1;
          ctl.res_last   = stat.prev_nil;
          ctl.res_vsel   = VS_CUR;
          ctl.list_step  = 1'b1;
          state_next     = stat.prev_nil ? S_IDLE : S_LIST_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/core/mqm_dp.sv
// Datapath of the multi-queue manager: link memories, queue tables,
// membership flags and the result register. Depends on mqm_pkg.
module mqm_dp #(
  parameter int MAX_CLIENTS = 64,
  parameter int MAX_QUEUES  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_wdata,
  input  logic [5:0]        cid_in,
  input  logic [3:0]        q_in,
  input  mqm_pkg::ctl_cmd_t ctl,
  output mqm_pkg::dp_stat_t stat,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [6:0]        out_value,
  output logic              out_hv,
  output logic              out_last
);
  import mqm_pkg::*;

  localparam int QD = (MAX_QUEUES < 16) ? MAX_QUEUES : 16;
  localparam int QW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW = $clog2(MAX_CLIENTS);
  localparam int LW = $clog2(MAX_CLIENTS + 1);
  localparam logic [LW-1:0] NIL = LW'(MAX_CLIENTS);

  logic [4:0]    num_queues;
  logic [5:0]    cid_r;
  logic [3:0]    q_r;
  logic [LW-1:0] cur;
  logic [LW-1:0] t_r;

  logic [MAX_CLIENTS-1:0] present;
  logic [LW-1:0] tail  [QD];
  logic [LW-1:0] count [QD];

  logic [QW-1:0] cq_mem   [MAX_CLIENTS];
  logic [LW-1:0] prev_mem [MAX_CLIENTS];
  logic [LW-1:0] next_mem [MAX_CLIENTS];
  logic [QW-1:0] cq_rd;
  logic [LW-1:0] prev_rd;
  logic [LW-1:0] next_rd;

  logic [CW-1:0] rd_addr;
  logic [CW-1:0] c_addr;
  logic [QW-1:0] qa;
  logic [LW-1:0] c_link;
  logic [6:0]    value_sel;

  assign c_addr = cid_r[CW-1:0];
  assign c_link = LW'(cid_r);
  assign qa     = q_r[QW-1:0];

  always_comb begin
    if (ctl.in_load) rd_addr = cid_in[CW-1:0];
    else if (ctl.rd_cur) rd_addr = cur[CW-1:0];
    else rd_addr = c_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_queues <= 5'd16;
    end else if (cfg_we) begin
      num_queues <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.in_load) begin
      cid_r <= cid_in;
      q_r   <= q_in;
    end
    if (ctl.list_init) cur <= tail[qa];
    else if (ctl.list_step) cur <= prev_rd;
    if (ctl.do_append) t_r <= tail[qa];
  end

  // Client tables: one read port each; prev_mem and next_mem are written at several addresses.
  always_ff @(posedge clk) begin
    cq_rd   <= cq_mem[rd_addr];
    prev_rd <= prev_mem[rd_addr];
    next_rd <= next_mem[rd_addr];
    if (ctl.do_append) begin
      cq_mem[c_addr]   <= qa;
      prev_mem[c_addr] <= tail[qa];
      next_mem[c_addr] <= NIL;
    end
    if (ctl.do_unlink) begin
      if (prev_rd < NIL) next_mem[prev_rd[CW-1:0]] <= next_rd;
      if (next_rd < NIL) prev_mem[next_rd[CW-1:0]] <= prev_rd;
    end
    if (ctl.do_link && t_r < NIL) next_mem[t_r[CW-1:0]] <= c_link;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      for (int i = 0; i < QD; i++) begin
        tail[i]  <= NIL;
        count[i] <= '0;
      end
    end else begin
      if (ctl.do_unlink) begin
        // The moved client leaves its old queue; its present flag stays set and append sets it again.
        if (next_rd >= NIL) tail[cq_rd] <= prev_rd;
        count[cq_rd] <= count[cq_rd] - LW'(1);
      end
      if (ctl.do_append) begin
        tail[qa]        <= c_link;
        count[qa]       <= count[qa] + LW'(1);
        present[c_addr] <= 1'b1;
      end
    end
  end

  always_comb begin
    unique case (ctl.res_vsel)
      VS_ZERO:  value_sel = '0;
      VS_QUEUE: value_sel = 7'(cq_rd);
      VS_COUNT: value_sel = 7'(count[qa]);
      VS_CUR:   value_sel = 7'(cur);
      default:  value_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (ctl.res_load) begin
      out_status <= ctl.res_status;
      out_value  <= value_sel;
      out_hv     <= ctl.res_hv;
      out_last   <= ctl.res_last;
    end
  end

  always_comb begin
    stat.q_ok     = ({1'b0, q_r} < num_queues) && (32'(q_r) < MAX_QUEUES);
    stat.cid_ok   = 32'(cid_r) < MAX_CLIENTS;
    stat.known    = stat.cid_ok && present[c_addr];
    stat.same_q   = q_r == 4'(cq_rd);
    stat.cur_nil  = cur >= NIL;
    stat.prev_nil = prev_rd >= NIL;
    stat.out_free = !out_valid || out_ready;
  end

endmodule

>>> rtl/core/multi_queue_manager_with_move_core.sv
// Top level of the multi-queue manager: sequencer plus datapath.
// Depends on mqm_pkg, mqm_ctrl and mqm_dp.
//
//  channel   direction  contents
//  s_axis    in         tdata: cmd[2:0] client_id[8:3] queue_index[12:9]
//  m_axis    out        tdata: status[1:0] value[8:2]; tuser: has_value; tlast: last
//  cfg       in         cfg_wdata: num_queues
//
// One command at a time. Count, query, rejected commands and a same-queue move go
// from the check state to the result register; new client runs append and link,
// move runs unlink, append and link. Listing alternates a read and an emit state
// per client, as the prev link read is registered. Reset is synchronous; membership
// flags and queue tables clear at once. A stalled result holds the walk in place.
module multi_queue_manager_with_move_core #(
  parameter int MAX_CLIENTS = 64,
  parameter int MAX_QUEUES  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // cmd, client_id, queue_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // status, value
  output logic [0:0]  m_axis_tuser,   // has_value
  output logic        m_axis_tlast
);
  import mqm_pkg::*;

  ctl_cmd_t   ctl;
  dp_stat_t   stat;
  logic [1:0] out_status;
  logic [6:0] out_value;

  mqm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tdata[2:0]),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  mqm_dp #(
    .MAX_CLIENTS (MAX_CLIENTS),
    .MAX_QUEUES  (MAX_QUEUES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cid_in     (s_axis_tdata[8:3]),
    .q_in       (s_axis_tdata[12:9]),
    .ctl        (ctl),
    .stat       (stat),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_status (out_status),
    .out_value  (out_value),
    .out_hv     (m_axis_tuser[0]),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, out_value, out_status};

endmodule

>>> rtl/core/mqm_checker.sv
// Port-level checks for the multi-queue manager, bound to the top level.
// Depends on multi_queue_manager_with_move_core.
module mqm_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_error_alone: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[1:0] != 2'd0) |-> (m_axis_tlast && !m_axis_tuser[0]))
    else $error("error status not a lone status-only result");

  a_no_value_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[8:2] == 7'd0 && m_axis_tlast))
    else $error("status-only result carries a value or is not last");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind multi_queue_manager_with_move_core mqm_checker u_mqm_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> tb/mqm_checker.sv
// Checker for the multi-queue manager: watches the command, result and config ports,
// keeps its own copy of the queue tables and compares every result transaction.
// Depends on mqm_pkg only.
module mqm_scoreboard (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mqm_pkg::*;

  localparam int NCLI = 64;
  localparam int NQ   = 16;
  localparam logic [6:0] NIL = 7'd64;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] value;
    logic       has_value;
    logic       last;
  } answer_t;

  answer_t    answers[$];
  logic [4:0] nq_reg;
  logic       present[NCLI];
  logic [3:0] home_q[NCLI];
  logic [6:0] prv[NCLI];
  logic [6:0] nxt[NCLI];
  logic [6:0] head[NQ];
  logic [6:0] tail[NQ];
  logic [6:0] cnt[NQ];

  assign pending = answers.size();

  function automatic bit queue_valid(logic [3:0] q);
    int lim;
    lim = (nq_reg > NQ) ? NQ : nq_reg;
    return q < lim;
  endfunction

  task automatic add_answer(answer_t a);
    answers.insert(answers.size(), a);
  endtask

  task automatic push_status(logic [1:0] st);
    add_answer('{st, 7'd0, 1'b0, 1'b1});
  endtask

  task automatic join_tail(int c, int q);
    prv[c] = tail[q];
    nxt[c] = NIL;
    if (tail[q] != NIL) nxt[tail[q]] = c[6:0];
    else head[q] = c[6:0];
    tail[q] = c[6:0];
    cnt[q] = cnt[q] + 7'd1;
    home_q[c] = q[3:0];
    present[c] = 1'b1;
  endtask

  task automatic detach(int c);
    int q;
    q = home_q[c];
    if (prv[c] != NIL) nxt[prv[c]] = nxt[c];
    else head[q] = nxt[c];
    if (nxt[c] != NIL) prv[nxt[c]] = prv[c];
    else tail[q] = prv[c];
    if (cnt[q] > 0) cnt[q] = cnt[q] - 7'd1;
    present[c] = 1'b0;
  endtask

  task automatic run_command(logic [2:0] cmd, logic [5:0] cid, logic [3:0] q);
    int cur;
    int k;
    int n;
    if (cmd == CMD_NEW) begin
      if (!queue_valid(q)) push_status(ST_BAD_QUEUE);
      else if (present[cid]) push_status(ST_DUPLICATE);
      else begin
        join_tail(cid, q);
        push_status(ST_OK);
      end
    end else if (cmd == CMD_MOVE) begin
      if (!queue_valid(q)) push_status(ST_BAD_QUEUE);
      else if (!present[cid]) push_status(ST_UNKNOWN);
      else begin
        if (home_q[cid] != q) begin
          detach(cid);
          join_tail(cid, q);
        end
        push_status(ST_OK);
      end
    end else if (cmd == CMD_QUERY) begin
      if (!present[cid]) push_status(ST_UNKNOWN);
      else add_answer('{ST_OK, {3'd0, home_q[cid]}, 1'b1, 1'b1});
    end else if (cmd == CMD_COUNT) begin
      if (!queue_valid(q)) push_status(ST_BAD_QUEUE);
      else add_answer('{ST_OK, cnt[q], 1'b1, 1'b1});
    end else if (cmd == CMD_LIST) begin
      if (!queue_valid(q)) push_status(ST_BAD_QUEUE);
      else begin
        n = (cnt[q] > NCLI) ? NCLI : cnt[q];
        cur = tail[q];
        k = 0;
        while (k < n && cur != NIL) begin
          add_answer('{ST_OK, cur[6:0], 1'b1, (k == n - 1 || prv[cur] == NIL)});
          cur = prv[cur];
          k++;
        end
        if (k == 0) push_status(ST_OK);
      end
    end
  endtask

  always @(posedge clk) begin
    answer_t want;
    answer_t got;
    if (rst) begin
      answers.delete();
      nq_reg = 5'd16;
      for (int i = 0; i < NCLI; i++) present[i] = 1'b0;
      for (int i = 0; i < NQ; i++) begin
        head[i] = NIL;
        tail[i] = NIL;
        cnt[i] = 7'd0;
      end
    end else begin
      // Results are compared before the new command so a same-edge command
      // never appears ahead of an older answer.
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[1:0], m_axis_tdata[8:2], m_axis_tuser[0], m_axis_tlast};
        if (answers.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          fail_count++;
        end else begin
          want = answers.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
            fail_count++;
          end
        end
      end
      if (cfg_we) nq_reg = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready)
        run_command(s_axis_tdata[2:0], s_axis_tdata[8:3], s_axis_tdata[12:9]);
    end
  end

  initial fail_count = 0;
endmodule

>>> tb/tb_multi_queue_manager_with_move_core.sv
// Top of the multi-queue manager testbench: clock, reset, command stimulus and verdict.
// Depends on mqm_pkg, the core and the mqm_scoreboard module.
module tb_multi_queue_manager_with_move_core;
  timeunit 1ns;
  timeprecision 1ps;
  import mqm_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = 5'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = 16'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  bit          rx_quiet = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  multi_queue_manager_with_move_core dut (.*);

  mqm_scoreboard checker_i (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver stalls; quiet phases keep tready high.
  always @(negedge clk) begin
    if (rst || rx_quiet) m_axis_tready <= 1'b1;
    else m_axis_tready <= (gap_len() == 0);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 4000000) begin
      $display("tb_multi_queue_manager_with_move_core: done, errors");
      $finish;
    end
  end

  // The valid drop of the previous transaction lands on a falling edge before
  // the next one is presented.
  task automatic send(logic [2:0] cmd, logic [5:0] cid, logic [3:0] q, bit gaps = 1);
    int g;
    g = gaps ? gap_len() : 0;
    repeat (g + 1) @(negedge clk);
    s_axis_tdata <= {3'd0, q, cid, cmd};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_queues(logic [4:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_cmd();
    int r;
    logic [2:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 35) cmd = CMD_NEW;
    else if (r < 60) cmd = CMD_MOVE;
    else if (r < 72) cmd = CMD_QUERY;
    else if (r < 82) cmd = CMD_COUNT;
    else if (r < 96) cmd = CMD_LIST;
    else cmd = 3'($urandom_range(5, 7));
    send(cmd, 6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)));
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    // Directed: empty list, errors, extremes, same-queue move, ignored codes.
    send(CMD_LIST, 6'd0, 4'd15);
    send(CMD_NEW, 6'd63, 4'd15);
    send(CMD_NEW, 6'd0, 4'd0);
    send(CMD_NEW, 6'd21, 4'd15);
    send(CMD_NEW, 6'd63, 4'd3);
    send(CMD_MOVE, 6'd42, 4'd1);
    send(CMD_QUERY, 6'd42, 4'd0);
    send(CMD_MOVE, 6'd21, 4'd15);
    send(CMD_MOVE, 6'd63, 4'd0);
    send(CMD_QUERY, 6'd63, 4'd0);
    send(CMD_COUNT, 6'd0, 4'd0);
    send(CMD_LIST, 6'd0, 4'd0);
    send(CMD_LIST, 6'd0, 4'd15);
    send(3'd5, 6'd1, 4'd1);
    send(3'd7, 6'd62, 4'd14);
    set_queues(5'd4);
    send(CMD_NEW, 6'd5, 4'd4);
    send(CMD_COUNT, 6'd0, 4'd15);
    send(CMD_QUERY, 6'd21, 4'd0);
    send(CMD_MOVE, 6'd21, 4'd2);
    send(CMD_LIST, 6'd0, 4'd4);
    set_queues(5'd0);
    send(CMD_NEW, 6'd7, 4'd0);
    send(CMD_LIST, 6'd0, 4'd0);
    set_queues(5'd31);
    // Fill many clients with tready always high, then wait for a full drain.
    rx_quiet = 1'b1;
    for (int i = 0; i < 64; i++) send(CMD_NEW, 6'(i), 4'($urandom_range(0, 3)), 0);
    for (int i = 0; i < 4; i++) send(CMD_LIST, 6'd0, 4'(i), 0);
    drain();
    rx_quiet = 1'b0;
    for (int i = 0; i < 70; i++) random_cmd();
    set_queues(5'd1);
    for (int i = 0; i < 30; i++) random_cmd();
    set_queues(5'($urandom_range(2, 15)));
    for (int i = 0; i < 60; i++) random_cmd();
    set_queues(5'd16);
    for (int i = 0; i < 20; i++) random_cmd();
    drain();
    if (fail_count == 0) $display("tb_multi_queue_manager_with_move_core: done, clean");
    else $display("tb_multi_queue_manager_with_move_core: done, errors");
    $finish;
  end
endmodule

>>> files.f
rtl/core/mqm_pkg.sv
rtl/core/mqm_ctrl.sv
rtl/core/mqm_dp.sv
rtl/core/multi_queue_manager_with_move_core.sv
rtl/core/mqm_checker.sv
tb/mqm_checker.sv
tb/tb_multi_queue_manager_with_move_core.sv
